@@ rtl/dtq_pkg.sv @@
// Shared types and constants of the deadline timer queue.
package dtq_pkg;

    localparam int TIME_W    = 64;
    localparam int SEQ_W     = 64;
    localparam int OUT_JOB_W = 32;
    localparam int MAX_OUT   = 32;
    localparam int OUT_AW    = $clog2(MAX_OUT);

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_EXPIRE   = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_EXPIRED  = 2'd2,
        ST_NONE_DUE = 2'd3
    } t_status;

    // Command to one row of cells.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_chain_cmd;

endpackage

@@ rtl/deadline_timer_queue_top.sv @@
// Top level of the deadline timer queue: two sorted cell rows and the item sequencer.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------------------
//  item     in         i_valid / o_stall    i_op, i_clock_sel, i_current_time, i_delay, i_job
//  result   out        o_valid / i_stall    o_status, o_due_job, o_armed_deadline, o_last
//
// Schedule: sum register, insert into the row, then report. Expire with n due jobs: the
// pop loop (one pop per cycle at the row head), then each result is read through the
// result store read port and emitted in turn; with none due, the report follows the pop
// loop. Reset is synchronous and clears the fill counts, the sequence counter and
// the control; the cells need no clearing pass. A stalled result holds the output
// register and the sequencer waits; the next item is taken as soon as the sequencer is idle.
module deadline_timer_queue_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int JOB_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic                              i_clock_sel,
    input  logic [dtq_pkg::TIME_W-1:0]        i_current_time,
    input  logic [dtq_pkg::TIME_W-1:0]        i_delay,
    input  logic [dtq_pkg::OUT_JOB_W-1:0]     i_job,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [dtq_pkg::OUT_JOB_W-1:0]     o_due_job,
    output logic [dtq_pkg::TIME_W-1:0]        o_armed_deadline,
    output logic                              o_last
);

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PCW = dtq_pkg::OUT_AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCHED,
        S_POP,
        S_ONE,
        S_RD,
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic                          r_q;
    logic [dtq_pkg::TIME_W-1:0]    r_now;
    logic [dtq_pkg::TIME_W-1:0]    r_dl;
    logic [JOB_WIDTH-1:0]          r_job;
    logic [dtq_pkg::SEQ_W-1:0]     r_seq_ctr;
    dtq_pkg::t_status              r_code;
    logic [PCW-1:0]                r_npop;
    logic [PCW-1:0]                r_rd_ptr;
    logic [JOB_WIDTH-1:0]          r_rd_job;

    // Output register.
    logic                          r_o_valid;
    dtq_pkg::t_status              r_o_status;
    logic [dtq_pkg::OUT_JOB_W-1:0] r_o_job;
    logic [dtq_pkg::TIME_W-1:0]    r_o_armed;
    logic                          r_o_last;

    // Store for the jobs popped by one expire item.
    logic [JOB_WIDTH-1:0]          mem [dtq_pkg::MAX_OUT];

    dtq_pkg::t_chain_cmd           cmd      [2];
    logic [dtq_pkg::TIME_W-1:0]    head_dl  [2];
    logic [JOB_WIDTH-1:0]          head_job [2];
    logic [CW-1:0]                 q_count  [2];

    logic                          accept;
    logic                          out_free;
    logic                          emit;
    logic [dtq_pkg::TIME_W:0]      sum;
    logic [dtq_pkg::TIME_W-1:0]    sat_dl;
    logic [63:0]                   in_job_ext;
    logic [63:0]                   rd_job_ext;
    logic [dtq_pkg::TIME_W-1:0]    sel_dl;
    logic [CW-1:0]                 sel_count;
    logic [dtq_pkg::TIME_W-1:0]    armed;
    logic                          q_full;
    logic                          pop_go;
    logic                          do_ins;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign emit     = out_free && ((r_state == S_ONE) || (r_state == S_EMIT));

    // Saturate the deadline to all ones on carry out.
    assign sum    = {1'b0, i_current_time} + {1'b0, i_delay};
    assign sat_dl = sum[dtq_pkg::TIME_W] ? '1 : sum[dtq_pkg::TIME_W-1:0];

    // Keep the handle in JOB_WIDTH bits; report it in the port width.
    assign in_job_ext = 64'(i_job);
    assign rd_job_ext = 64'(r_rd_job);

    assign sel_dl    = head_dl[r_q];
    assign sel_count = q_count[r_q];
    assign armed     = (sel_count != '0) ? sel_dl : '0;
    assign q_full    = (sel_count >= CW'(QUEUE_DEPTH));

    // Pop while the head is due and the per-item limit is not reached.
    assign pop_go = (r_state == S_POP) && (r_npop < PCW'(dtq_pkg::MAX_OUT))
                    && (sel_count != '0) && (sel_dl <= r_now);
    assign do_ins = (r_state == S_SCHED) && !q_full;

    for (genvar q = 0; q < 2; q++) begin : g_queue
        assign cmd[q].ins = do_ins && (r_q == 1'(q));
        assign cmd[q].pop = pop_go && (r_q == 1'(q));

        dtq_chain #(
            .DEPTH (QUEUE_DEPTH),
            .JW    (JOB_WIDTH),
            .CW    (CW)
        ) u_chain (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd[q]),
            .i_new_dl   (r_dl),
            .i_new_seq  (r_seq_ctr),
            .i_new_job  (r_job),
            .o_head_dl  (head_dl[q]),
            .o_head_job (head_job[q]),
            .o_count    (q_count[q])
        );
    end

    // Result store: write on pop, registered read while emitting.
    always_ff @(posedge i_clk) begin
        if (pop_go) begin
            mem[r_npop[dtq_pkg::OUT_AW-1:0]] <= head_job[r_q];
        end
        r_rd_job <= mem[r_rd_ptr[dtq_pkg::OUT_AW-1:0]];
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q   <= i_clock_sel;
            r_now <= i_current_time;
            r_dl  <= sat_dl;
            r_job <= in_job_ext[JOB_WIDTH-1:0];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seq_ctr <= '0;
            r_npop    <= '0;
            r_rd_ptr  <= '0;
            r_code    <= dtq_pkg::ST_ACCEPTED;
            r_o_valid <= 1'b0;
        end else begin
            // Load a fresh result when emitting, drop the old one once it transfers.
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_npop   <= '0;
                        r_rd_ptr <= '0;
                        r_state  <= (i_op == dtq_pkg::OP_EXPIRE) ? S_POP : S_SCHED;
                    end
                end
                S_SCHED: begin
                    // Insert into the row, or drop when full.
                    if (q_full) begin
                        r_code <= dtq_pkg::ST_FULL;
                    end else begin
                        r_code    <= dtq_pkg::ST_ACCEPTED;
                        r_seq_ctr <= r_seq_ctr + 64'd1;
                    end
                    r_state <= S_ONE;
                end
                S_POP: begin
                    if (pop_go) begin
                        r_npop <= r_npop + PCW'(1);
                    end else if (r_npop == '0) begin
                        r_code  <= dtq_pkg::ST_NONE_DUE;
                        r_state <= S_ONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_ONE: begin
                    if (out_free) begin
                        r_o_status <= r_code;
                        r_o_job    <= '0;
                        r_o_armed  <= armed;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_RD: begin
                    // Store read data lands in r_rd_job this edge.
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_status <= dtq_pkg::ST_EXPIRED;
                        r_o_job    <= rd_job_ext[dtq_pkg::OUT_JOB_W-1:0];
                        r_o_armed  <= armed;
                        r_o_last   <= (r_rd_ptr + PCW'(1) == r_npop);
                        r_rd_ptr   <= r_rd_ptr + PCW'(1);
                        r_state    <= (r_rd_ptr + PCW'(1) == r_npop) ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_due_job        = r_o_job;
    assign o_armed_deadline = r_o_armed;
    assign o_last           = r_o_last;

endmodule

@@ rtl/dtq_cell.sv @@
// One queue cell: holds one entry and hands it to a neighbor on insert or pop.
module dtq_cell #(
    parameter int JW = 32
) (
    input  logic                         i_clk,
    input  dtq_pkg::t_chain_cmd          i_cmd,
    input  logic                         i_occ,
    input  logic [dtq_pkg::TIME_W-1:0]   i_new_dl,
    input  logic [dtq_pkg::SEQ_W-1:0]    i_new_seq,
    input  logic [JW-1:0]                i_new_job,
    input  logic                         i_lt_goes,
    input  logic [dtq_pkg::TIME_W-1:0]   i_lt_dl,
    input  logic [dtq_pkg::SEQ_W-1:0]    i_lt_seq,
    input  logic [JW-1:0]                i_lt_job,
    input  logic [dtq_pkg::TIME_W-1:0]   i_rt_dl,
    input  logic [dtq_pkg::SEQ_W-1:0]    i_rt_seq,
    input  logic [JW-1:0]                i_rt_job,
    output logic                         o_goes,
    output logic [dtq_pkg::TIME_W-1:0]   o_dl,
    output logic [dtq_pkg::SEQ_W-1:0]    o_seq,
    output logic [JW-1:0]                o_job
);

    logic [dtq_pkg::TIME_W-1:0] r_dl;
    logic [dtq_pkg::SEQ_W-1:0]  r_seq;
    logic [JW-1:0]              r_job;

    // New entry belongs at or before this cell: cell empty, or held entry comes after it.
    assign o_goes = !i_occ || (r_dl > i_new_dl) || ((r_dl == i_new_dl) && (r_seq > i_new_seq));

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_dl  <= i_rt_dl;
            r_seq <= i_rt_seq;
            r_job <= i_rt_job;
        end else if (i_cmd.ins && o_goes) begin
            if (i_lt_goes) begin
                r_dl  <= i_lt_dl;
                r_seq <= i_lt_seq;
                r_job <= i_lt_job;
            end else begin
                r_dl  <= i_new_dl;
                r_seq <= i_new_seq;
                r_job <= i_new_job;
            end
        end
    end

    assign o_dl  = r_dl;
    assign o_seq = r_seq;
    assign o_job = r_job;

endmodule

@@ rtl/dtq_chain.sv @@
// Sorted row of cells for one queue, with its fill count.
module dtq_chain #(
    parameter int DEPTH = 32,
    parameter int JW    = 32,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtq_pkg::t_chain_cmd          i_cmd,
    input  logic [dtq_pkg::TIME_W-1:0]   i_new_dl,
    input  logic [dtq_pkg::SEQ_W-1:0]    i_new_seq,
    input  logic [JW-1:0]                i_new_job,
    output logic [dtq_pkg::TIME_W-1:0]   o_head_dl,
    output logic [JW-1:0]                o_head_job,
    output logic [CW-1:0]                o_count
);

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       goes [DEPTH];
    logic [dtq_pkg::TIME_W-1:0] dl   [DEPTH];
    logic [dtq_pkg::SEQ_W-1:0]  seq  [DEPTH];
    logic [JW-1:0]              job  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                       lt_goes;
        logic [dtq_pkg::TIME_W-1:0] lt_dl;
        logic [dtq_pkg::SEQ_W-1:0]  lt_seq;
        logic [JW-1:0]              lt_job;
        logic [dtq_pkg::TIME_W-1:0] rt_dl;
        logic [dtq_pkg::SEQ_W-1:0]  rt_seq;
        logic [JW-1:0]              rt_job;

        if (g == 0) begin : g_first
            assign lt_goes = 1'b0;
            assign lt_dl   = i_new_dl;
            assign lt_seq  = i_new_seq;
            assign lt_job  = i_new_job;
        end else begin : g_mid
            assign lt_goes = goes[g-1];
            assign lt_dl   = dl[g-1];
            assign lt_seq  = seq[g-1];
            assign lt_job  = job[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign rt_dl  = '0;
            assign rt_seq = '0;
            assign rt_job = '0;
        end else begin : g_body
            assign rt_dl  = dl[g+1];
            assign rt_seq = seq[g+1];
            assign rt_job = job[g+1];
        end

        dtq_cell #(
            .JW(JW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (i_cmd),
            .i_occ     (r_count > CW'(g)),
            .i_new_dl  (i_new_dl),
            .i_new_seq (i_new_seq),
            .i_new_job (i_new_job),
            .i_lt_goes (lt_goes),
            .i_lt_dl   (lt_dl),
            .i_lt_seq  (lt_seq),
            .i_lt_job  (lt_job),
            .i_rt_dl   (rt_dl),
            .i_rt_seq  (rt_seq),
            .i_rt_job  (rt_job),
            .o_goes    (goes[g]),
            .o_dl      (dl[g]),
            .o_seq     (seq[g]),
            .o_job     (job[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head_dl  = dl[0];
    assign o_head_job = job[0];
    assign o_count    = r_count;

endmodule
